FILE: rtl/core/mexp_pkg.sv
// Shared types and constants for the modular exponentiation unit.
// No dependencies; imported by every module under rtl/core.
package mexp_pkg;

  localparam int KEY_BITS = 64;
  localparam int WORD_W   = 64;
  localparam int CNT_W    = $clog2(KEY_BITS);
  localparam int CFG_IDX_W = 2;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS     = 2'd0,
    REG_PUBLIC_EXP  = 2'd1,
    REG_PRIVATE_EXP = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } mexp_state_t;

  typedef struct packed {
    logic start;
    key_t a;
    key_t b;
    key_t m;
  } mm_req_t;

endpackage

FILE: rtl/core/mexp_modmul.sv
// Bit-serial modular multiplier: r = a*b mod m, one bit of b per cycle, MSB first.
// Depends on mexp_pkg. Requires a < m (or a = 1) and m > 0.
module mexp_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  mexp_pkg::mm_req_t req,
  output logic             done,
  output mexp_pkg::key_t   result
);
  import mexp_pkg::*;

  key_t a_r, b_r, m_r, r_r;
  key_t r_nxt;
  cnt_t cnt_r;
  logic busy_r, done_r;

  logic [KEY_BITS+1:0] t_sum;
  logic [KEY_BITS+2:0] d1, d2;

  always_comb begin
    t_sum = {1'b0, r_r, 1'b0} + (b_r[KEY_BITS-1] ? (KEY_BITS+2)'(a_r) : '0);
    d1 = {1'b0, t_sum} - (KEY_BITS+3)'(m_r);
    d2 = {1'b0, t_sum} - (KEY_BITS+3)'({m_r, 1'b0});
    if (!d2[KEY_BITS+2]) begin
      r_nxt = d2[KEY_BITS-1:0];
    end else if (!d1[KEY_BITS+2]) begin
      r_nxt = d1[KEY_BITS-1:0];
    end else begin
      r_nxt = t_sum[KEY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= cnt_t'(KEY_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      a_r <= req.a;
      b_r <= req.b;
      m_r <= req.m;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= {b_r[KEY_BITS-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = r_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("modmul done longer than one cycle");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r)) else $error("modmul done without work");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !(done_r)) else $error("modmul busy and done together");

endmodule

FILE: rtl/core/mexp_seq.sv
// Square-and-multiply sequencer driving the shared modular multiplier.
// Depends on mexp_pkg; talks to mexp_modmul through mm_req_t.
module mexp_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             action,
  input  mexp_pkg::key_t   base_in,
  input  mexp_pkg::key_t   modulus,
  input  mexp_pkg::key_t   pub_exp,
  input  mexp_pkg::key_t   priv_exp,
  output logic             busy,
  output logic             res_valid,
  output mexp_pkg::key_t   res_value,
  output mexp_pkg::mm_req_t mm_req,
  input  logic             mm_done,
  input  mexp_pkg::key_t   mm_result
);
  import mexp_pkg::*;

  mexp_state_t state_r, state_nxt;
  key_t acc_r, acc_nxt, base_r, base_nxt, ex_r, ex_nxt;
  logic issued_r, issued_nxt;
  logic accept;

  assign accept = start && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (modulus == '0) ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mm_done) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (ex_r == '0) begin
          state_nxt = ST_DONE;
        end else if (ex_r[0]) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_done) state_nxt = ST_SQR;
      end
      ST_SQR: begin
        if (mm_done) state_nxt = ST_CHECK;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mm_req.start = 1'b0;
    mm_req.a     = base_r;
    mm_req.b     = base_r;
    mm_req.m     = modulus;
    case (state_r)
      ST_REDUCE: begin
        mm_req.start = !issued_r;
        mm_req.a     = key_t'(1);
      end
      ST_MUL: begin
        mm_req.start = !issued_r;
        mm_req.a     = acc_r;
      end
      ST_SQR: mm_req.start = !issued_r;
      default: mm_req.start = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    acc_nxt    = acc_r;
    base_nxt   = base_r;
    ex_nxt     = ex_r;
    issued_nxt = issued_r;
    if (mm_done) begin
      issued_nxt = 1'b0;
    end else if (mm_req.start) begin
      issued_nxt = 1'b1;
    end
    if (accept) begin
      acc_nxt  = (modulus > key_t'(1)) ? key_t'(1) : '0;
      base_nxt = base_in;
      ex_nxt   = action ? priv_exp : pub_exp;
    end else if (mm_done) begin
      case (state_r)
        ST_REDUCE: base_nxt = mm_result;
        ST_MUL:    acc_nxt  = mm_result;
        ST_SQR: begin
          base_nxt = mm_result;
          ex_nxt   = {1'b0, ex_r[KEY_BITS-1:1]};
        end
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    ex_r   <= ex_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res_value = acc_r;

  a_res_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (state_r == ST_IDLE)) else $error("result strobe not single beat");
  a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    mm_req.start |=> !mm_req.start) else $error("multiplier start repeated");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !issued_r) else $error("multiply pending while idle");
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != ST_IDLE) && (modulus != '0)) |-> (acc_r < modulus))
    else $error("accumulator not reduced");

endmodule

FILE: rtl/core/modular_exponentiation_unit.sv
// Modular exponentiation: base^exp mod modulus, right-to-left square-and-multiply.
// Steps: the base is reduced, then for each exponent bit a check, a multiply if the bit
// is set, and a square; multiplies run on mexp_modmul; a zero modulus skips to the result.
// busy holds from accept through the result beat; a new start is taken only when idle.
// Result is a single-cycle out_valid strobe; the receiver cannot stall.
// Synchronous active-low reset; modulus and both exponents reset to 1.
module modular_exponentiation_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_action,
  input  mexp_pkg::word_t       in_base_value,
  output logic                  out_valid,
  output mexp_pkg::word_t       out_power_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  mexp_pkg::word_t       cfg_data
);
  import mexp_pkg::*;

  key_t modulus_r, pub_exp_r, priv_exp_r;
  key_t res_value, mm_result;
  mm_req_t mm_req;
  logic mm_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= key_t'(1);
      pub_exp_r  <= key_t'(1);
      priv_exp_r <= key_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:     modulus_r  <= cfg_data[KEY_BITS-1:0];
        REG_PUBLIC_EXP:  pub_exp_r  <= cfg_data[KEY_BITS-1:0];
        REG_PRIVATE_EXP: priv_exp_r <= cfg_data[KEY_BITS-1:0];
        default:         modulus_r  <= modulus_r;
      endcase
    end
  end

  mexp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_action),
    .base_in   (in_base_value[KEY_BITS-1:0]),
    .modulus   (modulus_r),
    .pub_exp   (pub_exp_r),
    .priv_exp  (priv_exp_r),
    .busy      (busy),
    .res_valid (out_valid),
    .res_value (res_value),
    .mm_req    (mm_req),
    .mm_done   (mm_done),
    .mm_result (mm_result)
  );

  mexp_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mm_req),
    .done   (mm_done),
    .result (mm_result)
  );

  assign out_power_value = word_t'(res_value);

endmodule
